// ===== sv/cbpl_pkg.sv =====
// ----------------------------------------------------------------------------
// cbpl_pkg
// Shared widths, constants and controller/datapath interface types for the
// cubic Bezier point and length core.
// ----------------------------------------------------------------------------
package cbpl_pkg;

  localparam int unsigned MAX_SAMPLES = 1024;
  localparam int unsigned NUM_REGS    = 8;
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned T_W         = 17;
  localparam int unsigned N_W         = 11;
  localparam int unsigned LEN_W       = 27;
  localparam int unsigned D_W         = $clog2(MAX_SAMPLES);
  localparam int unsigned SQ_W        = 2 * T_W;
  localparam int unsigned PR_W        = SQ_W + T_W;
  localparam int unsigned W_W         = 25;
  localparam int unsigned ACC_W       = 43;
  localparam int unsigned RT_W        = 36;
  localparam int unsigned DIV_STEPS   = T_W;
  localparam int unsigned SQRT_STEPS  = RT_W / 2;
  localparam int unsigned CNT_W       = $clog2(SQRT_STEPS);
  localparam int unsigned PADDR_W     = $clog2(NUM_REGS) + 2;

  localparam logic [T_W-1:0]   ONE_T   = T_W'(65536);
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam logic [N_W-1:0]   N_MAX   = N_W'(MAX_SAMPLES);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic       load_in;
    logic       div_init;
    logic       div_step;
    logic       t_adv;
    logic       sq;
    logic       wa;
    logic       wb;
    logic       acc_en;
    logic [1:0] acc_k;
    logic       rnd;
    logic       seg;
    logic       sqrt_step;
    logic       sum_add;
    logic       cache_store;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic           mode;
    logic           hit;
    logic           few;
    logic [D_W-1:0] last_seg;
  } sts_t;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_CHK  = 14'b00000000000010,
    S_DIV  = 14'b00000000000100,
    S_ADV  = 14'b00000000001000,
    S_SQ   = 14'b00000000010000,
    S_WA   = 14'b00000000100000,
    S_WB   = 14'b00000001000000,
    S_ACC  = 14'b00000010000000,
    S_RND  = 14'b00000100000000,
    S_SEG  = 14'b00001000000000,
    S_SQRT = 14'b00010000000000,
    S_ADD  = 14'b00100000000000,
    S_FIN  = 14'b01000000000000,
    S_DONE = 14'b10000000000000
  } state_t;

endpackage

// ===== sv/cbpl_dp.sv =====
// ----------------------------------------------------------------------------
// cbpl_dp
// Datapath: Bezier weight products, coordinate accumulation, parameter
// stepping divider, chord square root, length sum and length cache.
// ----------------------------------------------------------------------------
module cbpl_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cbpl_pkg::cmd_t              cmd,
  output cbpl_pkg::sts_t              sts,
  input  logic                        cfg_clr,
  input  cbpl_pkg::coord_t            cfg_regs [cbpl_pkg::NUM_REGS],
  input  logic                        in_mode,
  input  logic [cbpl_pkg::T_W-1:0]    in_curve_param,
  input  logic [cbpl_pkg::N_W-1:0]    in_sample_count,
  output cbpl_pkg::coord_t            out_point_x,
  output cbpl_pkg::coord_t            out_point_y,
  output logic [cbpl_pkg::LEN_W-1:0]  out_curve_length
);

  localparam int unsigned T_W   = cbpl_pkg::T_W;
  localparam int unsigned D_W   = cbpl_pkg::D_W;
  localparam int unsigned SQ_W  = cbpl_pkg::SQ_W;
  localparam int unsigned PR_W  = cbpl_pkg::PR_W;
  localparam int unsigned W_W   = cbpl_pkg::W_W;
  localparam int unsigned ACC_W = cbpl_pkg::ACC_W;
  localparam int unsigned RT_W  = cbpl_pkg::RT_W;
  localparam int unsigned LEN_W = cbpl_pkg::LEN_W;
  localparam int unsigned N_W   = cbpl_pkg::N_W;
  localparam int unsigned MP_W  = W_W + 1 + cbpl_pkg::COORD_W;

  logic                  mode_r;
  logic [N_W-1:0]        n_r;
  logic [T_W-1:0]        t_r;
  logic [D_W-1:0]        r_cur_r;
  logic [T_W-1:0]        q_r;
  logic [D_W-1:0]        rem_r;
  logic [SQ_W-1:0]       uu_r, tt_r;
  logic [W_W-1:0]        w0_r, w1_r, w2_r, w3_r;
  logic signed [ACC_W-1:0] acc_x_r, acc_y_r;
  cbpl_pkg::coord_t      cur_x_r, cur_y_r, prev_x_r, prev_y_r;
  logic [RT_W-1:0]       sq_x_r, sq_res_r, sq_bit_r;
  logic [LEN_W-1:0]      sum_r;
  logic [LEN_W-1:0]      clen_r;
  logic [N_W-1:0]        ccnt_r;
  logic                  cvalid_r;
  cbpl_pkg::coord_t      opx_r, opy_r;
  logic [LEN_W-1:0]      olen_r;

  logic [N_W-1:0]        n_eff;
  logic [D_W-1:0]        d;
  logic [T_W-1:0]        u;
  logic [D_W:0]          div_tmp;
  logic [D_W:0]          rs;
  logic [PR_W-1:0]       pa, pb, pb3;
  logic [W_W-1:0]        wsel;
  logic signed [W_W:0]   ws;
  logic signed [MP_W-1:0] prod_x, prod_y;
  logic signed [ACC_W-1:0] base_x, base_y;
  logic signed [ACC_W-1:0] rb_x, rb_y;
  logic signed [ACC_W-1:0] sh_x, sh_y;
  logic signed [T_W-1:0] dxs, dys;
  logic [cbpl_pkg::COORD_W-1:0] dxa, dya;
  logic [RT_W-1:0]       s_sum;
  logic [RT_W-1:0]       sq_try;
  logic [LEN_W:0]        sum_wide;

  function automatic cbpl_pkg::coord_t sat_coord(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(32767)) begin
      return cbpl_pkg::coord_t'(16'sh7fff);
    end else if (v < -ACC_W'(32768)) begin
      return cbpl_pkg::coord_t'(16'sh8000);
    end
    return v[cbpl_pkg::COORD_W-1:0];
  endfunction

  assign n_eff = (n_r > cbpl_pkg::N_MAX) ? cbpl_pkg::N_MAX : n_r;
  assign d     = D_W'(n_eff - N_W'(1));
  assign u     = cbpl_pkg::ONE_T - t_r;

  assign sts.mode     = mode_r;
  assign sts.hit      = cvalid_r && (ccnt_r == n_r);
  assign sts.few      = (n_r < N_W'(2));
  assign sts.last_seg = d;

  assign div_tmp = {rem_r, q_r[T_W-1]};
  assign rs      = {1'b0, r_cur_r} + {1'b0, rem_r};

  always_comb begin
    pa = '0;
    pb = '0;
    if (cmd.wa) begin
      pa = PR_W'(uu_r) * PR_W'(u);
      pb = PR_W'(uu_r) * PR_W'(t_r);
    end else begin
      pa = PR_W'(tt_r) * PR_W'(t_r);
      pb = PR_W'(tt_r) * PR_W'(u);
    end
  end
  assign pb3 = pb + (pb << 1);

  always_comb begin
    case (cmd.acc_k)
      2'd0:    wsel = w0_r;
      2'd1:    wsel = w1_r;
      2'd2:    wsel = w2_r;
      default: wsel = w3_r;
    endcase
  end
  assign ws     = $signed({1'b0, wsel});
  assign prod_x = ws * cfg_regs[{cmd.acc_k, 1'b0}];
  assign prod_y = ws * cfg_regs[{cmd.acc_k, 1'b1}];
  assign base_x = (cmd.acc_k == 2'd0) ? '0 : acc_x_r;
  assign base_y = (cmd.acc_k == 2'd0) ? '0 : acc_y_r;

  assign rb_x = acc_x_r + ACC_W'(32'sd8388608);
  assign rb_y = acc_y_r + ACC_W'(32'sd8388608);
  assign sh_x = rb_x >>> 24;
  assign sh_y = rb_y >>> 24;

  assign dxs = T_W'(cur_x_r) - T_W'(prev_x_r);
  assign dys = T_W'(cur_y_r) - T_W'(prev_y_r);
  assign dxa = dxs[T_W-1] ? cbpl_pkg::COORD_W'(-dxs) : dxs[cbpl_pkg::COORD_W-1:0];
  assign dya = dys[T_W-1] ? cbpl_pkg::COORD_W'(-dys) : dys[cbpl_pkg::COORD_W-1:0];
  assign s_sum = RT_W'(dxa) * RT_W'(dxa) + RT_W'(dya) * RT_W'(dya);

  assign sq_try   = sq_res_r + sq_bit_r;
  assign sum_wide = {1'b0, sum_r} + (LEN_W + 1)'(sq_res_r);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r <= in_mode;
      n_r    <= in_sample_count;
      t_r    <= (in_curve_param > cbpl_pkg::ONE_T) ? cbpl_pkg::ONE_T : in_curve_param;
      sum_r  <= '0;
    end
    if (cmd.div_init) begin
      q_r     <= cbpl_pkg::ONE_T;
      rem_r   <= '0;
      t_r     <= '0;
      r_cur_r <= '0;
    end
    if (cmd.div_step) begin
      if (div_tmp >= {1'b0, d}) begin
        rem_r <= D_W'(div_tmp - {1'b0, d});
        q_r   <= {q_r[T_W-2:0], 1'b1};
      end else begin
        rem_r <= div_tmp[D_W-1:0];
        q_r   <= {q_r[T_W-2:0], 1'b0};
      end
    end
    if (cmd.t_adv) begin
      prev_x_r <= cur_x_r;
      prev_y_r <= cur_y_r;
      if (rs >= {1'b0, d}) begin
        t_r     <= t_r + q_r + T_W'(1);
        r_cur_r <= D_W'(rs - {1'b0, d});
      end else begin
        t_r     <= t_r + q_r;
        r_cur_r <= rs[D_W-1:0];
      end
    end
    if (cmd.sq) begin
      uu_r <= SQ_W'(u) * SQ_W'(u);
      tt_r <= SQ_W'(t_r) * SQ_W'(t_r);
    end
    if (cmd.wa) begin
      w0_r <= pa[48:24];
      w1_r <= pb3[48:24];
    end
    if (cmd.wb) begin
      w3_r <= pa[48:24];
      w2_r <= pb3[48:24];
    end
    if (cmd.acc_en) begin
      acc_x_r <= base_x + ACC_W'(prod_x);
      acc_y_r <= base_y + ACC_W'(prod_y);
    end
    if (cmd.rnd) begin
      cur_x_r <= sat_coord(sh_x);
      cur_y_r <= sat_coord(sh_y);
    end
    if (cmd.seg) begin
      sq_x_r   <= s_sum;
      sq_res_r <= '0;
      sq_bit_r <= RT_W'(1) << (RT_W - 2);
    end
    if (cmd.sqrt_step) begin
      if (sq_x_r >= sq_try) begin
        sq_x_r   <= sq_x_r - sq_try;
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
    if (cmd.sum_add) begin
      sum_r <= (sum_wide > (LEN_W + 1)'(cbpl_pkg::LEN_MAX)) ? cbpl_pkg::LEN_MAX
                                                           : sum_wide[LEN_W-1:0];
    end
    if (cmd.out_load) begin
      opx_r  <= mode_r ? '0 : cur_x_r;
      opy_r  <= mode_r ? '0 : cur_y_r;
      olen_r <= mode_r ? clen_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvalid_r <= 1'b0;
      clen_r   <= '0;
      ccnt_r   <= '0;
    end else if (cfg_clr) begin
      cvalid_r <= 1'b0;
    end else if (cmd.cache_store) begin
      cvalid_r <= 1'b1;
      clen_r   <= sum_r;
      ccnt_r   <= n_r;
    end
  end

  assign out_point_x      = opx_r;
  assign out_point_y      = opy_r;
  assign out_curve_length = olen_r;

endmodule

// ===== sv/cbpl_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbpl_ctrl
// Controller: sequences point evaluation, the step divider, chord square
// roots and the length sum, and owns the channel handshakes.
// ----------------------------------------------------------------------------
module cbpl_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  cbpl_pkg::sts_t sts,
  output cbpl_pkg::cmd_t cmd
);

  localparam int unsigned CNT_W = cbpl_pkg::CNT_W;
  localparam int unsigned D_W   = cbpl_pkg::D_W;

  cbpl_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [D_W-1:0]   seg_r, seg_nxt;
  logic             first_r, first_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    seg_nxt   = seg_r;
    first_nxt = first_r;
    cmd       = '0;
    unique case (state_r)
      cbpl_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = cbpl_pkg::S_CHK;
        end
      end
      cbpl_pkg::S_CHK: begin
        if (!sts.mode) begin
          state_nxt = cbpl_pkg::S_SQ;
        end else if (sts.hit) begin
          state_nxt = cbpl_pkg::S_DONE;
        end else if (sts.few) begin
          state_nxt = cbpl_pkg::S_FIN;
        end else begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = cbpl_pkg::S_DIV;
        end
      end
      cbpl_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(cbpl_pkg::DIV_STEPS - 1)) begin
          first_nxt = 1'b1;
          seg_nxt   = D_W'(1);
          state_nxt = cbpl_pkg::S_SQ;
        end
      end
      cbpl_pkg::S_ADV: begin
        cmd.t_adv = 1'b1;
        state_nxt = cbpl_pkg::S_SQ;
      end
      cbpl_pkg::S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = cbpl_pkg::S_WA;
      end
      cbpl_pkg::S_WA: begin
        cmd.wa    = 1'b1;
        state_nxt = cbpl_pkg::S_WB;
      end
      cbpl_pkg::S_WB: begin
        cmd.wb    = 1'b1;
        cnt_nxt   = '0;
        state_nxt = cbpl_pkg::S_ACC;
      end
      cbpl_pkg::S_ACC: begin
        cmd.acc_en = 1'b1;
        cmd.acc_k  = cnt_r[1:0];
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(3)) begin
          state_nxt = cbpl_pkg::S_RND;
        end
      end
      cbpl_pkg::S_RND: begin
        cmd.rnd = 1'b1;
        if (!sts.mode) begin
          state_nxt = cbpl_pkg::S_DONE;
        end else if (first_r) begin
          first_nxt = 1'b0;
          state_nxt = cbpl_pkg::S_ADV;
        end else begin
          state_nxt = cbpl_pkg::S_SEG;
        end
      end
      cbpl_pkg::S_SEG: begin
        cmd.seg   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = cbpl_pkg::S_SQRT;
      end
      cbpl_pkg::S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(cbpl_pkg::SQRT_STEPS - 1)) begin
          state_nxt = cbpl_pkg::S_ADD;
        end
      end
      cbpl_pkg::S_ADD: begin
        cmd.sum_add = 1'b1;
        if (seg_r == sts.last_seg) begin
          state_nxt = cbpl_pkg::S_FIN;
        end else begin
          seg_nxt   = seg_r + D_W'(1);
          state_nxt = cbpl_pkg::S_ADV;
        end
      end
      cbpl_pkg::S_FIN: begin
        cmd.cache_store = 1'b1;
        state_nxt       = cbpl_pkg::S_DONE;
      end
      cbpl_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = cbpl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cbpl_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || cmd.out_load;
  assign in_ready      = (state_r == cbpl_pkg::S_IDLE);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cbpl_pkg::S_IDLE;
      cnt_r       <= '0;
      seg_r       <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      seg_r       <= seg_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("Controller state is not one-hot.");

  a_accept_chk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == cbpl_pkg::S_CHK))
    else $error("Accepted transaction did not enter the check state.");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cbpl_pkg::S_DONE && out_valid_r && !out_ready)
      |=> (state_r == cbpl_pkg::S_DONE && out_valid_r))
    else $error("Finished result overwrote a pending transaction.");

  a_sqrt_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cbpl_pkg::S_SQRT) |-> (cnt_r < CNT_W'(cbpl_pkg::SQRT_STEPS)))
    else $error("Square root step counter out of range.");

endmodule

// ===== sv/cubic_bezier_point_and_length_core.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_point_and_length_core
// Point evaluation runs the weight and accumulate sequence before out_valid.
// Length on a cache miss runs the 18-step chord square root per segment,
// with n capped at 1024; a cache hit or a count below 2 skips the segment loop.
// One transaction is in flight at a time, and a stalled result holds the
// next one in its done state until out_ready takes the pending result.
// Synchronous active-low reset clears control, length cache and curve registers.
// ----------------------------------------------------------------------------
module cubic_bezier_point_and_length_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cbpl_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_mode,
  input  logic [cbpl_pkg::T_W-1:0]            in_curve_param,
  input  logic [cbpl_pkg::N_W-1:0]            in_sample_count,
  output logic                                out_valid,
  input  logic                                out_ready,
  output cbpl_pkg::coord_t                    out_point_x,
  output cbpl_pkg::coord_t                    out_point_y,
  output logic [cbpl_pkg::LEN_W-1:0]          out_curve_length
);

  localparam int unsigned IDX_W = cbpl_pkg::PADDR_W - 2;

  cbpl_pkg::coord_t regs_r [cbpl_pkg::NUM_REGS];
  logic             cfg_wr;
  logic [IDX_W-1:0] idx;
  cbpl_pkg::cmd_t   cmd;
  cbpl_pkg::sts_t   sts;

  assign pready = 1'b1;
  assign idx    = paddr[cbpl_pkg::PADDR_W-1:2];
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = {{(32 - cbpl_pkg::COORD_W){1'b0}}, regs_r[idx]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cbpl_pkg::NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      regs_r[idx] <= pwdata[cbpl_pkg::COORD_W-1:0];
    end
  end

  cbpl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cbpl_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_clr          (cfg_wr),
    .cfg_regs         (regs_r),
    .in_mode          (in_mode),
    .in_curve_param   (in_curve_param),
    .in_sample_count  (in_sample_count),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_curve_length (out_curve_length)
  );

endmodule
